/* src/plc_pkg.sv */
// Package with the request and result types and the shared constants of the list store.
`default_nettype none

package plc_pkg;

	// Fixed field widths of the request and result transfers.
	localparam int OP_W   = 2;
	localparam int POS_W  = 8;
	localparam int IN_HW  = 16;
	localparam int STAT_W = 2;
	localparam int OUT_HW = 16;
	localparam int LEN_W  = 9;

	// Defaults for the top-level parameters.
	localparam int DEF_CAPACITY    = 256;
	localparam int DEF_HANDLE_BITS = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_NULL  = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  position;
		logic [IN_HW-1:0]  entry_handle;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [OUT_HW-1:0] handle_out;
		logic [LEN_W-1:0]  list_length;
	} res_t;

endpackage

`default_nettype wire

/* src/plc_mem.sv */
// Simple dual-port entry memory with one write port and a registered read port.
`default_nettype none

module plc_mem
	import plc_pkg::*;
#(
	parameter int DEPTH = DEF_CAPACITY,
	parameter int WIDTH = DEF_HANDLE_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/plc_seq.sv */
// Request sequencer: length register, shift loop over the entry memory and result register.
`default_nettype none

module plc_seq
	import plc_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire req_t                        req,
	output logic                             busy,
	output logic                             done,
	output res_t                             result,
	output logic                             mem_we,
	output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
	output logic [HANDLE_BITS-1:0]           mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
	input  wire logic [HANDLE_BITS-1:0]      mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INS   = 5'b00010,
		S_FETCH = 5'b00100,
		S_FOUND = 5'b01000,
		S_DEL   = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          ptr_q;
	logic [CW-1:0]          pos_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [HANDLE_BITS-1:0] found_q;
	logic                   is_del_q;
	logic                   mv_s1;
	logic [AW-1:0]          mv_addr_s1;
	logic                   done_q;
	res_t                   res_q;

	logic                   accept;
	logic [HANDLE_BITS-1:0] in_h;
	logic [MW-1:0]          pos_w;
	logic [MW-1:0]          cnt_w;
	logic [CW-1:0]          ins_p;
	logic                   full;
	logic                   range_err;
	logic                   ins_direct;

	assign accept    = start && (state_q == S_IDLE);
	assign in_h      = HANDLE_BITS'(req.entry_handle);
	assign pos_w     = MW'(req.position);
	assign cnt_w     = MW'(count_q);
	assign ins_p     = (pos_w > cnt_w) ? count_q : CW'(req.position);
	assign full      = (count_q == CW'(CAPACITY));
	assign range_err = (pos_w >= cnt_w);
	// An insert at the tail needs no shift and is written in the accept cycle.
	assign ins_direct = accept && (req.op == OP_INSERT) && (in_h != '0) && !full
		&& (ins_p == count_q);

	// Write port: a pending move always wins; the final handle write waits for it.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = mv_addr_s1;
		mem_wdata = mem_rdata;
		if (mv_s1) begin
			mem_we = 1'b1;
		end else if (ins_direct) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(ins_p);
			mem_wdata = in_h;
		end else if ((state_q == S_INS) && (ptr_q == pos_q)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(pos_q);
			mem_wdata = hnd_q;
		end
	end

	always_comb begin
		unique case (state_q)
			S_INS:   mem_raddr = AW'(ptr_q - CW'(1));
			S_DEL:   mem_raddr = AW'(ptr_q);
			default: mem_raddr = AW'(pos_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			mv_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_INSERT: begin
								if (in_h == '0) begin
									done_q <= 1'b1;
									res_q  <= '{ST_NULL, '0, LEN_W'(count_q)};
								end else if (full) begin
									done_q <= 1'b1;
									res_q  <= '{ST_FULL, '0, LEN_W'(count_q)};
								end else if (ins_p == count_q) begin
									count_q <= count_q + CW'(1);
									done_q  <= 1'b1;
									res_q   <= '{ST_OK, '0, LEN_W'(count_q + CW'(1))};
								end else begin
									ptr_q   <= count_q;
									pos_q   <= ins_p;
									hnd_q   <= in_h;
									state_q <= S_INS;
								end
							end
							OP_DELETE, OP_GET: begin
								if (range_err) begin
									done_q <= 1'b1;
									res_q  <= '{ST_RANGE, '0, LEN_W'(count_q)};
								end else begin
									pos_q    <= CW'(req.position);
									is_del_q <= (req.op == OP_DELETE);
									state_q  <= S_FETCH;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
								res_q   <= '{ST_OK, '0, '0};
							end
						endcase
					end
				end
				S_INS: begin
					if (ptr_q != pos_q) begin
						mv_s1      <= 1'b1;
						mv_addr_s1 <= AW'(ptr_q);
						ptr_q      <= ptr_q - CW'(1);
					end else if (!mv_s1) begin
						count_q <= count_q + CW'(1);
						done_q  <= 1'b1;
						res_q   <= '{ST_OK, '0, LEN_W'(count_q + CW'(1))};
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					ptr_q   <= pos_q + CW'(1);
					state_q <= S_FOUND;
				end
				S_FOUND: begin
					found_q <= mem_rdata;
					if (is_del_q) begin
						state_q <= S_DEL;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{ST_OK, OUT_HW'(mem_rdata), LEN_W'(count_q)};
						state_q <= S_IDLE;
					end
				end
				S_DEL: begin
					if (ptr_q < count_q) begin
						mv_s1      <= 1'b1;
						mv_addr_s1 <= AW'(ptr_q - CW'(1));
						ptr_q      <= ptr_q + CW'(1);
					end else begin
						// The last pending move lands at this same edge.
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						res_q   <= '{ST_OK, OUT_HW'(found_q), LEN_W'(count_q - CW'(1))};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* src/positional_list_store.sv */
// Top level of the positional list store: sequencer plus entry memory.
//
//   Channel   Ports                    Transfer taken when
//   request   start, busy, req         rising edge with start high and busy low
//   result    done, result             rising edge that ends the cycle done is high
//
// Clear, delete and get errors, insert errors and inserts at the tail finish in the
// accept cycle: the result shows on the next cycle and busy stays low.
// An insert at position p shifts the entries from p on up by one, then writes the
// handle at p; a delete at p reads the entry, then shifts the entries above p down
// by one; a get only reads. The shift moves one entry per cycle through the single
// read and single write port of the memory, so at most CAPACITY - 1 entries move.
// Reset (arst_n low) empties the list at once; the memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module positional_list_store
	import plc_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	localparam int AW = $clog2(CAPACITY);

	// Memory port signals between the sequencer and the entry store.
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [HANDLE_BITS-1:0] mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [HANDLE_BITS-1:0] mem_rdata;

	// The sequencer owns the list length and walks the shift loop, issuing one
	// read and one write-back per cycle.
	plc_seq #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entries live here in list order; only reads at positions below the length are
	// ever used, so the contents after reset never reach a result.
	plc_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (HANDLE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// A multi-cycle request always ends with its result in the same cycle.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// No result is presented while a request is still in progress.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Error results are produced directly from the accepted request.
	a_err_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> $past(start && !busy))
		else $error("error result not tied to an accept in the previous cycle");

	// Errors never return a handle (inserts return none as well, but this check covers only errors).
	a_err_hnd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.handle_out == '0))
		else $error("error result carries a handle");
`endif

endmodule

`default_nettype wire
